// ----- rtl/core/rslp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rslp_pkg: shared types and helpers for the regime-switched linear predictor
// Word layouts, sequencer states, register indexes, saturation and regime classify.
// ----------------------------------------------------------------------------
package rslp_pkg;

   localparam int NUM_FLOWS_DEF  = 4;
   localparam int MAX_PASSES_DEF = 10;
   localparam int IN_FLOWS       = 4;

   localparam int MUL_A_W = 16;
   localparam int MUL_B_W = 33;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 35;

   typedef logic [7:0] csr_index_type;

   localparam csr_index_type REG_WEIGHT_TABLE   = 8'd0;
   localparam csr_index_type REG_FLOW_BIAS      = 8'd1;
   localparam csr_index_type REG_THRESHOLD_LOW  = 8'd2;
   localparam csr_index_type REG_THRESHOLD_HIGH = 8'd3;
   localparam csr_index_type REG_SLOPE_TABLE    = 8'd4;
   localparam csr_index_type REG_OFFSET_ZERO    = 8'd5;
   localparam csr_index_type REG_OFFSET_ONE     = 8'd6;
   localparam csr_index_type REG_OFFSET_TWO     = 8'd7;

   typedef logic [1:0] regime_type;

   localparam regime_type REGIME_LOW  = 2'd0;
   localparam regime_type REGIME_MID  = 2'd1;
   localparam regime_type REGIME_HIGH = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DOT_MUL,
      S_DOT_ACC,
      S_FLOW,
      S_LVL_MUL,
      S_LVL_ADD,
      S_OUT
   } state_type;

   typedef struct packed {
      logic        req_ready;
      logic        mul_en;
      logic        mul_level;
      logic        acc_en;
      logic        flow_en;
      logic        level_en;
      logic        rsp_load;
   } ctrl_type;

   typedef struct packed {
      logic [15:0] flow_a;
      logic [15:0] flow_b;
      logic [15:0] flow_c;
      logic [15:0] flow_d;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] flow_estimate;
      logic signed [31:0] level_estimate;
      regime_type         regime_out;
   } rsp_word_type;

   typedef struct packed {
      csr_index_type index;
      logic [63:0]   data;
   } csr_word_type;

   function automatic logic signed [31:0] sat_to_32(input logic signed [40:0] v);
      logic signed [31:0] r;
      if (v > 41'sd2147483647) begin
         r = 32'sh7fff_ffff;
      end else if (v < -41'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic regime_type classify(input logic signed [31:0] level,
                                           input logic signed [31:0] lo,
                                           input logic signed [31:0] hi);
      regime_type r;
      if (level < lo) begin
         r = REGIME_LOW;
      end else if (level > hi) begin
         r = REGIME_HIGH;
      end else begin
         r = REGIME_MID;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/rslp_chan_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rslp_chan_if: valid/ready channel
// Carries one word of the given payload type per handshake.
// ----------------------------------------------------------------------------
interface rslp_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/rslp_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rslp_mul: shared signed multiplier
// 16 x 33 bit signed product, registered, used for every weight and slope.
// ----------------------------------------------------------------------------
module rslp_mul (
   input  wire logic                                   clock,
   input  wire logic                                   en,
   input  wire logic signed [rslp_pkg::MUL_A_W-1:0]    op_a,
   input  wire logic signed [rslp_pkg::MUL_B_W-1:0]    op_b,
   output logic signed [rslp_pkg::MUL_P_W-1:0]         prod
);
   import rslp_pkg::*;

   logic signed [MUL_P_W-1:0] prod_ff;
   logic signed [MUL_P_W-1:0] prod_in;

   always_comb begin
      prod_in = MUL_P_W'(op_a) * MUL_P_W'(op_b);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

// ----- rtl/core/regime_switched_linear_predictor_unit.sv -----
// Sequence: accept, a multiply and accumulate per flow, the flow result, then
//   1..MAX_PASSES regime passes of multiply and add, then the result word.
// A new word is accepted only in idle, after the result is loaded; the single
//   shared multiplier serves every weight and every regime pass.
// Reset: synchronous, active high; clears regime, config and handshakes.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// regime_switched_linear_predictor_unit: piecewise linear level predictor
// Weighted flow sum, then regime passes of slope*flow+offset with reclassify.
// ----------------------------------------------------------------------------
module regime_switched_linear_predictor_unit #(
   parameter int NUM_FLOWS  = rslp_pkg::NUM_FLOWS_DEF,
   parameter int MAX_PASSES = rslp_pkg::MAX_PASSES_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   rslp_chan_if.sink   req_if,
   rslp_chan_if.source rsp_if,
   rslp_chan_if.sink   csr_if
);
   import rslp_pkg::*;

   localparam int FLW = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
   localparam int PW  = (MAX_PASSES > 1) ? $clog2(MAX_PASSES) : 1;

   // config
   logic [63:0]        weight_table_ff;
   logic signed [31:0] flow_bias_ff;
   logic signed [31:0] threshold_low_ff;
   logic signed [31:0] threshold_high_ff;
   logic [47:0]        slope_table_ff;
   logic signed [31:0] offset_zero_ff;
   logic signed [31:0] offset_one_ff;
   logic signed [31:0] offset_two_ff;

   state_type state_ff, state_in;
   ctrl_type  ctrl;

   logic [15:0]          flows_ff [NUM_FLOWS];
   logic [15:0]          in_flows [IN_FLOWS];
   logic [FLW-1:0]       flow_idx_ff;
   logic [PW-1:0]        pass_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [31:0]   flow_ff;
   logic signed [31:0]   level_ff;
   regime_type           regime_ff;
   logic                 rsp_valid_ff;
   rsp_word_type         rsp_word_ff;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] prod;

   regime_type           r_eff;
   regime_type           next_regime;
   logic [1:0]           w_sel;
   logic signed [15:0]   weight_cur;
   logic signed [15:0]   slope_cur;
   logic signed [31:0]   offset_cur;
   logic signed [ACC_W-1:0] acc_rnd;
   logic signed [40:0]   flow_sum;
   logic signed [47:0]   prod_rnd;
   logic signed [40:0]   level_sum;
   logic signed [31:0]   flow_sat;
   logic signed [31:0]   level_sat;
   logic                 last_flow;
   logic                 last_pass;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_table_ff   <= '0;
         flow_bias_ff      <= '0;
         threshold_low_ff  <= '0;
         threshold_high_ff <= '0;
         slope_table_ff    <= '0;
         offset_zero_ff    <= '0;
         offset_one_ff     <= '0;
         offset_two_ff     <= '0;
      end else if (csr_if.valid) begin
         case (csr_if.payload.index)
            REG_WEIGHT_TABLE:   weight_table_ff   <= csr_if.payload.data;
            REG_FLOW_BIAS:      flow_bias_ff      <= csr_if.payload.data[31:0];
            REG_THRESHOLD_LOW:  threshold_low_ff  <= csr_if.payload.data[31:0];
            REG_THRESHOLD_HIGH: threshold_high_ff <= csr_if.payload.data[31:0];
            REG_SLOPE_TABLE:    slope_table_ff    <= csr_if.payload.data[47:0];
            REG_OFFSET_ZERO:    offset_zero_ff    <= csr_if.payload.data[31:0];
            REG_OFFSET_ONE:     offset_one_ff     <= csr_if.payload.data[31:0];
            REG_OFFSET_TWO:     offset_two_ff     <= csr_if.payload.data[31:0];
            default: ;
         endcase
      end
   end

   // datapath selects
   always_comb begin
      r_eff = (regime_ff > REGIME_HIGH) ? REGIME_HIGH : regime_ff;
      w_sel = 2'(flow_idx_ff);
      weight_cur = weight_table_ff[16*w_sel +: 16];
      case (r_eff)
         REGIME_LOW: begin
            slope_cur  = slope_table_ff[15:0];
            offset_cur = offset_zero_ff;
         end
         REGIME_MID: begin
            slope_cur  = slope_table_ff[31:16];
            offset_cur = offset_one_ff;
         end
         default: begin
            slope_cur  = slope_table_ff[47:32];
            offset_cur = offset_two_ff;
         end
      endcase
      if (ctrl.mul_level) begin
         mul_a = slope_cur;
         mul_b = MUL_B_W'(flow_ff);
      end else begin
         mul_a = weight_cur;
         mul_b = {{(MUL_B_W-16){1'b0}}, flows_ff[flow_idx_ff]};
      end
      // round half up, then add bias or offset
      acc_rnd   = (acc_ff + ACC_W'(8192)) >>> 14;
      flow_sum  = 41'(acc_rnd) + 41'(flow_bias_ff);
      flow_sat  = sat_to_32(flow_sum);
      prod_rnd  = (prod[47:0] + 48'sd128) >>> 8;
      level_sum = 41'($signed(prod_rnd[39:0])) + 41'(offset_cur);
      level_sat = sat_to_32(level_sum);
      next_regime = classify(level_sat, threshold_low_ff, threshold_high_ff);
      last_flow = (flow_idx_ff == FLW'(NUM_FLOWS - 1));
      last_pass = (pass_ff == PW'(MAX_PASSES - 1));
   end

   rslp_mul u_mul (
      .clock (clock),
      .en    (ctrl.mul_en),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (req_if.valid) state_in = S_DOT_MUL;
         S_DOT_MUL: state_in = S_DOT_ACC;
         S_DOT_ACC: state_in = last_flow ? S_FLOW : S_DOT_MUL;
         S_FLOW:    state_in = S_LVL_MUL;
         S_LVL_MUL: state_in = S_LVL_ADD;
         S_LVL_ADD: begin
            if (next_regime == r_eff || last_pass) begin
               state_in = S_OUT;
            end else begin
               state_in = S_LVL_MUL;
            end
         end
         S_OUT:     if (!rsp_valid_ff || rsp_if.ready) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         S_IDLE:    ctrl.req_ready = 1'b1;
         S_DOT_MUL: ctrl.mul_en = 1'b1;
         S_DOT_ACC: ctrl.acc_en = 1'b1;
         S_FLOW:    ctrl.flow_en = 1'b1;
         S_LVL_MUL: begin
            ctrl.mul_en    = 1'b1;
            ctrl.mul_level = 1'b1;
         end
         S_LVL_ADD: ctrl.level_en = 1'b1;
         S_OUT:     ctrl.rsp_load = !rsp_valid_ff || rsp_if.ready;
         default: ;
      endcase
   end

   assign req_if.ready = ctrl.req_ready;

   always_comb begin
      in_flows[0] = req_if.payload.flow_a;
      in_flows[1] = req_if.payload.flow_b;
      in_flows[2] = req_if.payload.flow_c;
      in_flows[3] = req_if.payload.flow_d;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         regime_ff    <= REGIME_LOW;
         rsp_valid_ff <= 1'b0;
         flow_idx_ff  <= '0;
         pass_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (ctrl.req_ready && req_if.valid) begin
            flow_idx_ff <= '0;
            pass_ff     <= '0;
         end
         if (ctrl.acc_en && !last_flow) begin
            flow_idx_ff <= flow_idx_ff + 1'b1;
         end
         if (ctrl.level_en) begin
            regime_ff <= next_regime;
            if (!last_pass) begin
               pass_ff <= pass_ff + 1'b1;
            end
         end
         if (ctrl.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.req_ready && req_if.valid) begin
         for (int i = 0; i < NUM_FLOWS; i++) begin
            flows_ff[i] <= in_flows[i];
         end
         acc_ff <= '0;
      end
      if (ctrl.acc_en) begin
         acc_ff <= acc_ff + prod[ACC_W-1:0];
      end
      if (ctrl.flow_en) begin
         flow_ff <= flow_sat;
      end
      if (ctrl.level_en) begin
         level_ff <= level_sat;
      end
      if (ctrl.rsp_load) begin
         rsp_word_ff.flow_estimate  <= flow_ff;
         rsp_word_ff.level_estimate <= level_ff;
         rsp_word_ff.regime_out     <= regime_ff;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_word_ff;

   a_regime_range: assert property (@(posedge clock) disable iff (reset)
      regime_ff != 2'd3)
      else $error("regime index out of range");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> (state_ff == S_DOT_MUL))
      else $error("accepted word did not start the weighted sum");

   a_pass_bound: assert property (@(posedge clock) disable iff (reset)
      pass_ff <= PW'(MAX_PASSES - 1))
      else $error("pass counter beyond limit");

   a_load_clears_out: assert property (@(posedge clock) disable iff (reset)
      ctrl.rsp_load |=> (rsp_if.valid && state_ff == S_IDLE))
      else $error("result word not presented after load");

endmodule
`default_nettype wire
